/* sv/assert_macros.svh */
// Assertion helpers used by the ALU checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define SM83_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define SM83_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* sv/sm83_pkg.sv */
`timescale 1ns / 1ps

package sm83_pkg;

  // flag bit positions
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  // unprefixed opcodes decoded by exact match
  localparam logic [7:0] OP_RLCA      = 8'h07;
  localparam logic [7:0] OP_RRCA      = 8'h0F;
  localparam logic [7:0] OP_RLA       = 8'h17;
  localparam logic [7:0] OP_RRA       = 8'h1F;
  localparam logic [7:0] OP_DAA       = 8'h27;
  localparam logic [7:0] OP_CPL       = 8'h2F;
  localparam logic [7:0] OP_SCF       = 8'h37;
  localparam logic [7:0] OP_CCF       = 8'h3F;
  localparam logic [7:0] OP_ADD_SP_E  = 8'hE8;
  localparam logic [7:0] OP_LD_HL_SPE = 8'hF8;

  // pattern matches
  localparam logic [7:0] MASK_ALU_IMM = 8'hC7;
  localparam logic [7:0] PAT_ALU_IMM  = 8'hC6;
  localparam logic [7:0] MASK_ADD_HL  = 8'hCF;
  localparam logic [7:0] PAT_ADD_HL   = 8'h09;
  localparam logic [2:0] LOW_INC      = 3'd4;
  localparam logic [2:0] LOW_DEC      = 3'd5;
  localparam logic [2:0] REG_A        = 3'd7;

  // CB groups and unprefixed groups (opcode bits 7..6)
  localparam logic [1:0] CB_SHIFT = 2'd0;
  localparam logic [1:0] CB_BIT   = 2'd1;
  localparam logic [1:0] CB_RES   = 2'd2;
  localparam logic [1:0] CB_SET   = 2'd3;
  localparam logic [1:0] GRP_ALU  = 2'd2;
  localparam logic [1:0] GRP_LOW  = 2'd0;

  // DAA constants
  localparam logic [7:0] DAA_HI    = 8'h60;
  localparam logic [7:0] DAA_LO    = 8'h06;
  localparam logic [7:0] DAA_LIMIT = 8'h99;
  localparam logic [3:0] DAA_NIB   = 4'h9;

  typedef enum logic [2:0] {
    ALU_ADD = 3'd0, ALU_ADC = 3'd1, ALU_SUB = 3'd2, ALU_SBC = 3'd3,
    ALU_AND = 3'd4, ALU_XOR = 3'd5, ALU_OR  = 3'd6, ALU_CP  = 3'd7
  } alu_kind_e;

  typedef enum logic [2:0] {
    SH_RLC = 3'd0, SH_RRC = 3'd1, SH_RL  = 3'd2, SH_RR  = 3'd3,
    SH_SLA = 3'd4, SH_SRA = 3'd5, SH_SWAP = 3'd6, SH_SRL = 3'd7
  } shift_kind_e;

  typedef struct packed {
    logic [7:0] res;
    logic [3:0] flags;
  } alu_res_t;

  typedef struct packed {
    logic [7:0] val;
    logic       cout;
  } shift_res_t;

  function automatic alu_res_t alu8(alu_kind_e kind, logic [7:0] a, logic [7:0] v,
                                    logic cin);
    alu_res_t   o;
    logic       c;
    logic [8:0] s;
    logic [4:0] h;
    logic [7:0] r;
    o = '0;
    c = 1'b0;
    s = '0;
    h = '0;
    r = a;
    case (kind)
      ALU_ADD, ALU_ADC: begin
        c = (kind == ALU_ADC) ? cin : 1'b0;
        s = {1'b0, a} + {1'b0, v} + {8'd0, c};
        h = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, c};
        o.flags[FLAG_H] = h[4];
        o.flags[FLAG_C] = s[8];
        r = s[7:0];
      end
      ALU_SUB, ALU_SBC, ALU_CP: begin
        c = (kind == ALU_SBC) ? cin : 1'b0;
        o.flags[FLAG_H] = {1'b0, a[3:0]} < ({1'b0, v[3:0]} + {4'd0, c});
        o.flags[FLAG_C] = {1'b0, a} < ({1'b0, v} + {8'd0, c});
        o.flags[FLAG_N] = 1'b1;
        r = a - v - {7'd0, c};
      end
      ALU_AND: begin
        r = a & v;
        o.flags[FLAG_H] = 1'b1;
      end
      ALU_XOR: r = a ^ v;
      default: r = a | v;
    endcase
    o.flags[FLAG_Z] = (r == 8'd0);
    o.res = (kind == ALU_CP) ? a : r;
    return o;
  endfunction

  function automatic shift_res_t shift8(shift_kind_e kind, logic [7:0] v, logic cin);
    shift_res_t o;
    case (kind)
      SH_RLC:  o = '{val: {v[6:0], v[7]}, cout: v[7]};
      SH_RRC:  o = '{val: {v[0], v[7:1]}, cout: v[0]};
      SH_RL:   o = '{val: {v[6:0], cin}, cout: v[7]};
      SH_RR:   o = '{val: {cin, v[7:1]}, cout: v[0]};
      SH_SLA:  o = '{val: {v[6:0], 1'b0}, cout: v[7]};
      SH_SRA:  o = '{val: {v[7], v[7:1]}, cout: v[0]};
      SH_SWAP: o = '{val: {v[3:0], v[7:4]}, cout: 1'b0};
      default: o = '{val: {1'b0, v[7:1]}, cout: v[0]};
    endcase
    return o;
  endfunction

endpackage

/* sv/sm83_alu.sv */
`timescale 1ns / 1ps
// SM83 ALU: one operation per item, decoded from opcode and CB prefix.
// An item passes the input register, then the result register; out_valid_o
// rises when it moves from the input register into the result register.
// Throughput: one item per cycle while the consumer does not stall, set by the
// single combinational decode/ALU pass between the two registers.
// Reset (rst_ni low, async) empties both stages; payload registers keep data.

module sm83_alu (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        prefixed_i,
  input  logic [7:0]  opcode_i,
  input  logic [7:0]  acc_i,
  input  logic [7:0]  operand_i,
  input  logic [3:0]  flags_in_i,
  input  logic [15:0] word_left_i,
  input  logic [15:0] word_right_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  acc_out_o,
  output logic [7:0]  value_out_o,
  output logic        writes_value_o,
  output logic [15:0] word_out_o,
  output logic [3:0]  flags_out_o,
  output logic        known_op_o
);

  // ---------------------------------------------------------------------------
  // Stage 1: input register. Refills whenever it is empty or its item moves on.
  // ---------------------------------------------------------------------------
  logic        s1_valid_q;
  logic        pre_q;
  logic [7:0]  op_q;
  logic [7:0]  a_q;
  logic [7:0]  v_q;
  logic [3:0]  f_q;
  logic [15:0] wl_q;
  logic [15:0] wr_q;

  logic s2_ready;
  logic s1_ready;

  assign s2_ready   = !out_valid_o || out_ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      pre_q <= prefixed_i;
      op_q  <= opcode_i;
      a_q   <= acc_i;
      v_q   <= operand_i;
      f_q   <= flags_in_i;
      wl_q  <= word_left_i;
      wr_q  <= word_right_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Decode and compute. Defaults pass everything through unchanged.
  // ---------------------------------------------------------------------------
  logic [7:0]  ao_d;
  logic [7:0]  vo_d;
  logic [15:0] wo_d;
  logic [3:0]  fo_d;
  logic        wrv_d;
  logic        known_d;

  logic [2:0]               y;
  logic                     to_a;
  sm83_pkg::alu_res_t       alu_r;
  sm83_pkg::shift_res_t     sh_r;
  logic [16:0]              hl_sum;
  logic [12:0]              hl_h;
  logic [4:0]               sp_h;
  logic [8:0]               sp_c;
  logic [7:0]               daa_r;
  logic                     daa_c;

  assign y = op_q[5:3];

  always_comb begin
    ao_d    = a_q;
    vo_d    = v_q;
    wo_d    = wl_q;
    fo_d    = f_q;
    wrv_d   = 1'b0;
    known_d = 1'b1;
    to_a    = 1'b0;
    alu_r   = sm83_pkg::alu8(sm83_pkg::alu_kind_e'(y), a_q, v_q, f_q[sm83_pkg::FLAG_C]);
    sh_r    = '0;
    hl_sum  = {1'b0, wl_q} + {1'b0, wr_q};
    hl_h    = {1'b0, wl_q[11:0]} + {1'b0, wr_q[11:0]};
    sp_h    = {1'b0, wl_q[3:0]} + {1'b0, v_q[3:0]};
    sp_c    = {1'b0, wl_q[7:0]} + {1'b0, v_q};
    daa_r   = a_q;
    daa_c   = f_q[sm83_pkg::FLAG_C];

    if (pre_q) begin
      to_a = (op_q[2:0] == sm83_pkg::REG_A);
      case (op_q[7:6])
        sm83_pkg::CB_SHIFT: begin
          sh_r  = sm83_pkg::shift8(sm83_pkg::shift_kind_e'(y), v_q, f_q[sm83_pkg::FLAG_C]);
          vo_d  = sh_r.val;
          fo_d  = {(sh_r.val == 8'd0), 2'b00, sh_r.cout};
          wrv_d = 1'b1;
        end
        sm83_pkg::CB_BIT: begin
          // BIT keeps carry and writes nothing back
          fo_d = {~v_q[y], 1'b0, 1'b1, f_q[sm83_pkg::FLAG_C]};
          to_a = 1'b0;
        end
        sm83_pkg::CB_RES: begin
          vo_d  = v_q & ~(8'd1 << y);
          wrv_d = 1'b1;
        end
        default: begin
          vo_d  = v_q | (8'd1 << y);
          wrv_d = 1'b1;
        end
      endcase
    end else if (op_q[7:6] == sm83_pkg::GRP_ALU
                 || (op_q & sm83_pkg::MASK_ALU_IMM) == sm83_pkg::PAT_ALU_IMM) begin
      // register and immediate accumulator ops share one unit
      ao_d = alu_r.res;
      fo_d = alu_r.flags;
    end else if (op_q == sm83_pkg::OP_RLCA || op_q == sm83_pkg::OP_RRCA
                 || op_q == sm83_pkg::OP_RLA || op_q == sm83_pkg::OP_RRA) begin
      // accumulator rotates always clear Z
      sh_r = sm83_pkg::shift8(sm83_pkg::shift_kind_e'(y), a_q, f_q[sm83_pkg::FLAG_C]);
      ao_d = sh_r.val;
      fo_d = {3'b000, sh_r.cout};
    end else if (op_q[7:6] == sm83_pkg::GRP_LOW && op_q[2:0] == sm83_pkg::LOW_INC) begin
      vo_d  = v_q + 8'd1;
      fo_d  = {(vo_d == 8'd0), 1'b0, (v_q[3:0] == 4'hF), f_q[sm83_pkg::FLAG_C]};
      wrv_d = 1'b1;
      to_a  = (y == sm83_pkg::REG_A);
    end else if (op_q[7:6] == sm83_pkg::GRP_LOW && op_q[2:0] == sm83_pkg::LOW_DEC) begin
      vo_d  = v_q - 8'd1;
      fo_d  = {(vo_d == 8'd0), 1'b1, (v_q[3:0] == 4'h0), f_q[sm83_pkg::FLAG_C]};
      wrv_d = 1'b1;
      to_a  = (y == sm83_pkg::REG_A);
    end else if ((op_q & sm83_pkg::MASK_ADD_HL) == sm83_pkg::PAT_ADD_HL) begin
      // ADD HL,rr: half carry out of bit 11, Z kept
      wo_d = hl_sum[15:0];
      fo_d = {f_q[sm83_pkg::FLAG_Z], 1'b0, hl_h[12], hl_sum[16]};
    end else if (op_q == sm83_pkg::OP_ADD_SP_E || op_q == sm83_pkg::OP_LD_HL_SPE) begin
      // flags come from the unsigned low-byte add
      wo_d = wl_q + {{8{v_q[7]}}, v_q};
      fo_d = {2'b00, sp_h[4], sp_c[8]};
    end else if (op_q == sm83_pkg::OP_DAA) begin
      if (!f_q[sm83_pkg::FLAG_N]) begin
        if (f_q[sm83_pkg::FLAG_C] || a_q > sm83_pkg::DAA_LIMIT) begin
          daa_r = daa_r + sm83_pkg::DAA_HI;
          daa_c = 1'b1;
        end
        if (f_q[sm83_pkg::FLAG_H] || a_q[3:0] > sm83_pkg::DAA_NIB) begin
          daa_r = daa_r + sm83_pkg::DAA_LO;
        end
      end else begin
        if (f_q[sm83_pkg::FLAG_C]) begin
          daa_r = daa_r - sm83_pkg::DAA_HI;
        end
        if (f_q[sm83_pkg::FLAG_H]) begin
          daa_r = daa_r - sm83_pkg::DAA_LO;
        end
      end
      ao_d = daa_r;
      fo_d = {(daa_r == 8'd0), f_q[sm83_pkg::FLAG_N], 1'b0, daa_c};
    end else if (op_q == sm83_pkg::OP_CPL) begin
      ao_d = ~a_q;
      fo_d = f_q | 4'b0110;
    end else if (op_q == sm83_pkg::OP_SCF) begin
      fo_d = {f_q[sm83_pkg::FLAG_Z], 3'b001};
    end else if (op_q == sm83_pkg::OP_CCF) begin
      fo_d = {f_q[sm83_pkg::FLAG_Z], 2'b00, ~f_q[sm83_pkg::FLAG_C]};
    end else begin
      known_d = 1'b0;
    end

    // a write-back target of A also lands in the accumulator
    if (wrv_d && to_a) begin
      ao_d = vo_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: result register, holds while the consumer stalls.
  // ---------------------------------------------------------------------------
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      acc_out_o      <= ao_d;
      value_out_o    <= vo_d;
      writes_value_o <= wrv_d;
      word_out_o     <= wo_d;
      flags_out_o    <= fo_d;
      known_op_o     <= known_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* sv/sm83_alu_chk.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sm83_alu_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  acc_out_o,
  input logic [3:0]  flags_out_o,
  input logic        writes_value_o,
  input logic        known_op_o
);

  // a stalled item keeps its payload
  `SM83_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(acc_out_o) && $stable(flags_out_o), "stalled result changed")

  // an edge seen in reset leaves the result stage empty
  `SM83_ASSERT_ALWAYS(a_rst_empty, !rst_ni |=> !out_valid_o, "result valid during reset")

  // an accepted item reaches the output after passing both stages
  `SM83_ASSERT(a_latency, in_valid_i && in_ready_o |-> ##2 out_valid_o, "accepted item not delivered")

  // unknown opcodes never write back
  `SM83_ASSERT(a_unknown_nowr, out_valid_o && !known_op_o |-> !writes_value_o, "write-back on unknown opcode")

endmodule

bind sm83_alu sm83_alu_chk u_sm83_alu_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .acc_out_o      (acc_out_o),
  .flags_out_o    (flags_out_o),
  .writes_value_o (writes_value_o),
  .known_op_o     (known_op_o)
);
